[rtl/core/slhist_pkg.sv]
// Shared constants and the module size pattern for the shuffled layout start histogram.
// No dependencies; the top level refers to it by scoped names.
package slhist_pkg;

	localparam int PATTERN_LEN = 11;
	localparam int GROUP_SIZE  = 55;
	localparam int SIZE_W      = 5;
	localparam int WORD_W      = 32;
	localparam int BIN_W       = 8;

	// Request codes on req_type and result codes on result_kind.
	localparam logic REQ_SHUFFLE = 1'b0;
	localparam logic REQ_READ    = 1'b1;
	localparam logic KIND_START  = 1'b0;
	localparam logic KIND_COUNT  = 1'b1;

	typedef logic [SIZE_W-1:0] size_t;

	// Module size by position in the repeating pattern.
	function automatic size_t pattern_size(input logic [3:0] idx);
		size_t s;
		case (idx)
			4'd0:    s = 5'd6;
			4'd1:    s = 5'd5;
			4'd2:    s = 5'd5;
			4'd3:    s = 5'd8;
			4'd4:    s = 5'd16;
			4'd5:    s = 5'd1;
			4'd6:    s = 5'd4;
			4'd7:    s = 5'd4;
			4'd8:    s = 5'd4;
			4'd9:    s = 5'd1;
			4'd10:   s = 5'd1;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

endpackage

[rtl/core/slhist_ram.sv]
// Single write port, single read port memory with registered read data.
// No dependencies; used for the order store and for the histogram.
module slhist_ram #(
	parameter int DEPTH = 44,
	parameter int WIDTH = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/shuffled_layout_start_histogram.sv]
// Shuffle item: reads the partner entry, then writes both swapped entries; the last step of
// a run then starts a scan of the order store, one entry per cycle until id zero is found or
// the last entry is reached, then updates the histogram and gives the result. Read item:
// reads the bin and gives the result. One item is in work at a time, through the single
// order store port and histogram port. After reset a clearing pass writes the identity order
// and zero bins; no item is accepted until it ends. Uses slhist_pkg and slhist_ram.
module shuffled_layout_start_histogram #(
	parameter int NUM_GROUPS  = 4,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic [slhist_pkg::WORD_W-1:0]   random_word,
	input  logic [slhist_pkg::BIN_W-1:0]    bin_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            result_kind,
	output logic [slhist_pkg::WORD_W-1:0]   value
);

	localparam int NUM_ITEMS = slhist_pkg::PATTERN_LEN * NUM_GROUPS;
	localparam int TOTAL     = slhist_pkg::GROUP_SIZE * NUM_GROUPS;
	localparam int ITEM_W    = $clog2(NUM_ITEMS);
	localparam int ADDR_W    = $clog2(TOTAL);
	localparam int ENTRY_W   = slhist_pkg::SIZE_W + ITEM_W;
	localparam int WORD_W    = slhist_pkg::WORD_W;
	localparam int PROD_W    = WORD_W + ITEM_W + 1;

	typedef enum logic [10:0] {
		ST_CLEAR   = 11'b000_0000_0001,
		ST_IDLE    = 11'b000_0000_0010,
		ST_SW_RDJ  = 11'b000_0000_0100,
		ST_SW_WRP  = 11'b000_0000_1000,
		ST_SW_WRJ  = 11'b000_0001_0000,
		ST_SCAN_RD = 11'b000_0010_0000,
		ST_SCAN_EV = 11'b000_0100_0000,
		ST_HIST_WR = 11'b000_1000_0000,
		ST_BIN_RD  = 11'b001_0000_0000,
		ST_OUT     = 11'b010_0000_0000,
		ST_SPARE   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	logic [ADDR_W-1:0]      clr_idx_q;
	logic [3:0]             clr_mod_q;
	logic [ITEM_W-1:0]      pos_q;
	logic [ITEM_W-1:0]      swp_p_q, swp_j_q;
	logic [ENTRY_W-1:0]     tmp_q;
	logic [ITEM_W-1:0]      scan_q;
	logic [ADDR_W-1:0]      acc_q;
	logic [ADDR_W-1:0]      hist_addr_q;
	logic                   bin_ok_q;
	logic                   res_kind_q;
	logic [WORD_W-1:0]      res_val_q;
	logic                   out_valid_q;
	logic                   out_kind_q;
	logic [WORD_W-1:0]      out_val_q;

	// Order store and histogram ports.
	logic                   ord_we;
	logic [ITEM_W-1:0]      ord_waddr, ord_raddr;
	logic [ENTRY_W-1:0]     ord_wdata, ord_rdata;
	logic                   hist_we;
	logic [ADDR_W-1:0]      hist_waddr, hist_raddr;
	logic [COUNT_WIDTH-1:0] hist_wdata, hist_rdata;

	logic [ITEM_W-1:0]      p_eff;
	logic [PROD_W-1:0]      prod;
	logic [ITEM_W:0]        j_full;
	logic [ITEM_W-1:0]      j_sel;
	logic [ITEM_W-1:0]      rd_id;
	logic [ADDR_W-1:0]      rd_size;
	logic [ADDR_W-1:0]      scan_sum;
	logic                   scan_stop;
	logic [ADDR_W-1:0]      found_addr;
	logic                   bin_ok;
	logic                   slot_free;
	logic                   accept;

	slhist_ram #(.DEPTH(NUM_ITEMS), .WIDTH(ENTRY_W)) u_order (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.raddr (ord_raddr),
		.rdata (ord_rdata)
	);

	slhist_ram #(.DEPTH(TOTAL), .WIDTH(COUNT_WIDTH)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// Partner index: high word of random_word * (p + 1).
	assign p_eff  = (pos_q == '0 || 32'(pos_q) >= NUM_ITEMS) ? ITEM_W'(NUM_ITEMS - 1) : pos_q;
	assign prod   = PROD_W'(random_word) * PROD_W'({1'b0, p_eff} + (ITEM_W+1)'(1));
	assign j_full = prod[PROD_W-1:WORD_W];
	assign j_sel  = (j_full > {1'b0, p_eff}) ? p_eff : j_full[ITEM_W-1:0];

	// Scan of the order store: each entry carries its id and its module size.
	assign rd_id      = ord_rdata[ITEM_W-1:0];
	assign rd_size    = ADDR_W'(ord_rdata[ENTRY_W-1:ITEM_W]);
	assign scan_sum   = acc_q + rd_size;
	assign scan_stop  = (rd_id == '0) || (32'(scan_q) == NUM_ITEMS - 1);
	assign found_addr = (rd_id == '0) ? acc_q : scan_sum;

	assign bin_ok = 32'(bin_index) < TOTAL;

	always_comb begin
		ord_we     = 1'b0;
		ord_waddr  = ITEM_W'(clr_idx_q);
		ord_wdata  = {slhist_pkg::pattern_size(clr_mod_q), ITEM_W'(clr_idx_q)};
		ord_raddr  = scan_q;
		hist_we    = 1'b0;
		hist_waddr = clr_idx_q;
		hist_wdata = '0;
		hist_raddr = found_addr;
		unique case (state_q) inside
			ST_CLEAR: begin
				ord_we  = 32'(clr_idx_q) < NUM_ITEMS;
				hist_we = 1'b1;
			end
			ST_IDLE: begin
				ord_raddr  = p_eff;
				hist_raddr = ADDR_W'(bin_index);
			end
			ST_SW_RDJ: begin
				ord_raddr = swp_j_q;
			end
			ST_SW_WRP: begin
				ord_we    = 1'b1;
				ord_waddr = swp_p_q;
				ord_wdata = ord_rdata;
			end
			ST_SW_WRJ: begin
				ord_we    = 1'b1;
				ord_waddr = swp_j_q;
				ord_wdata = tmp_q;
			end
			ST_SCAN_RD: begin
				ord_raddr = scan_q;
			end
			ST_SCAN_EV: begin
				ord_raddr = scan_q + ITEM_W'(1);
			end
			ST_HIST_WR: begin
				hist_we    = 32'(hist_addr_q) < TOTAL;
				hist_waddr = hist_addr_q;
				hist_wdata = (hist_rdata == '1) ? hist_rdata : hist_rdata + COUNT_WIDTH'(1);
			end
			ST_BIN_RD, ST_OUT, ST_SPARE: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (32'(clr_idx_q) == TOTAL - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = (req_type == slhist_pkg::REQ_READ) ? ST_BIN_RD : ST_SW_RDJ;
				end
			end
			ST_SW_RDJ:  state_d = ST_SW_WRP;
			ST_SW_WRP:  state_d = ST_SW_WRJ;
			ST_SW_WRJ:  state_d = (swp_p_q > ITEM_W'(1)) ? ST_IDLE : ST_SCAN_RD;
			ST_SCAN_RD: state_d = ST_SCAN_EV;
			ST_SCAN_EV: begin
				if (scan_stop) begin
					state_d = ST_HIST_WR;
				end
			end
			ST_HIST_WR: state_d = ST_OUT;
			ST_BIN_RD:  state_d = ST_OUT;
			ST_OUT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SPARE:   state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			clr_mod_q   <= '0;
			pos_q       <= ITEM_W'(NUM_ITEMS - 1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + ADDR_W'(1);
				clr_mod_q <= (clr_mod_q == 4'(slhist_pkg::PATTERN_LEN - 1)) ?
					4'd0 : clr_mod_q + 4'd1;
			end
			if (state_q == ST_SW_WRJ) begin
				pos_q <= (swp_p_q > ITEM_W'(1)) ? swp_p_q - ITEM_W'(1) :
					ITEM_W'(NUM_ITEMS - 1);
			end
			if (state_q == ST_OUT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers; none of them needs a reset value.
	always_ff @(posedge clk) begin
		if (accept) begin
			swp_p_q  <= p_eff;
			swp_j_q  <= j_sel;
			bin_ok_q <= bin_ok;
		end
		if (state_q == ST_SW_RDJ) begin
			tmp_q <= ord_rdata;
		end
		if (state_q == ST_SW_WRJ) begin
			scan_q <= '0;
			acc_q  <= '0;
		end
		if (state_q == ST_SCAN_EV && !scan_stop) begin
			scan_q <= scan_q + ITEM_W'(1);
			acc_q  <= scan_sum;
		end
		if (state_q == ST_SCAN_EV && scan_stop) begin
			hist_addr_q <= found_addr;
		end
		if (state_q == ST_HIST_WR) begin
			res_kind_q <= slhist_pkg::KIND_START;
			res_val_q  <= WORD_W'(hist_addr_q);
		end
		if (state_q == ST_BIN_RD) begin
			res_kind_q <= slhist_pkg::KIND_COUNT;
			res_val_q  <= bin_ok_q ? WORD_W'(hist_rdata) : '0;
		end
		if (state_q == ST_OUT && slot_free) begin
			out_kind_q <= res_kind_q;
			out_val_q  <= res_val_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign value       = out_val_q;

endmodule
